[src/assert_macros.svh]
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define TFSP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("%m failed");

// property checked at every rising clock edge, reset included
`define TFSP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("%m failed");

`endif

[src/tfsp_pkg.sv]
// shared types and constants of the tagged fifo with selective pop
package tfsp_pkg;

  localparam int unsigned QueueDepth  = 16;
  localparam int unsigned PayloadBits = 32;
  localparam int unsigned TagBits     = 16;
  localparam int unsigned FrontDepth  = 2;

  // request codes as they arrive on tuser
  typedef enum logic [1:0] {
    REQ_PUSH = 2'd0,
    REQ_POP  = 2'd1,
    REQ_TERM = 2'd2,
    REQ_NONE = 2'd3
  } req_type_e;

  // result status codes as they leave on tuser
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_BLOCK = 2'd1,
    STAT_END   = 2'd2,
    STAT_FULL  = 2'd3
  } status_e;

  // pop mode bits, cleared for other requests
  typedef struct packed {
    logic match_any;
    logic blocking;
  } pop_flags_t;

  // back end sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH_ALLOC,
    S_PUSH_LINK,
    S_WALK,
    S_UNLINK,
    S_FREE,
    S_RESP
  } seq_state_e;

endpackage

[src/tfsp_front.sv]
// front end: takes requests, classifies them and buffers them for the back end
module tfsp_front #(
  parameter int unsigned PAYLOAD_BITS = tfsp_pkg::PayloadBits,
  parameter int unsigned TAG_BITS     = tfsp_pkg::TagBits
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_valid_i,
  output logic                    s_ready_o,
  input  logic [1:0]              s_type_i,
  input  logic [PAYLOAD_BITS-1:0] s_payload_i,
  input  logic [TAG_BITS-1:0]     s_tag_i,
  input  logic                    s_match_any_i,
  input  logic                    s_blocking_i,
  output logic                    req_valid_o,
  input  logic                    req_ready_i,
  output tfsp_pkg::req_type_e     req_kind_o,
  output tfsp_pkg::pop_flags_t    req_flags_o,
  output logic [PAYLOAD_BITS-1:0] req_payload_o,
  output logic [TAG_BITS-1:0]     req_tag_o
);

  localparam int unsigned PW = $clog2(tfsp_pkg::FrontDepth);
  localparam int unsigned CW = $clog2(tfsp_pkg::FrontDepth + 1);

  tfsp_pkg::req_type_e  kind_q [tfsp_pkg::FrontDepth];
  tfsp_pkg::pop_flags_t flags_q [tfsp_pkg::FrontDepth];
  logic [PAYLOAD_BITS-1:0] pay_q [tfsp_pkg::FrontDepth];
  logic [TAG_BITS-1:0]     tag_q [tfsp_pkg::FrontDepth];

  logic [PW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          push, pop;
  tfsp_pkg::req_type_e  kind_in;
  tfsp_pkg::pop_flags_t flags_in;

  // classify: mode bits only matter for a pop
  always_comb begin
    kind_in  = tfsp_pkg::req_type_e'(s_type_i);
    flags_in = '0;
    if (kind_in == tfsp_pkg::REQ_POP) begin
      flags_in.match_any = s_match_any_i;
      flags_in.blocking  = s_blocking_i;
    end
  end

  assign s_ready_o   = (cnt_q != CW'(tfsp_pkg::FrontDepth));
  assign req_valid_o = (cnt_q != '0);
  assign push        = s_valid_i & s_ready_o;
  assign pop         = req_valid_o & req_ready_i;

  assign req_kind_o    = kind_q[rptr_q];
  assign req_flags_o   = flags_q[rptr_q];
  assign req_payload_o = pay_q[rptr_q];
  assign req_tag_o     = tag_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == PW'(tfsp_pkg::FrontDepth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = (rptr_q == PW'(tfsp_pkg::FrontDepth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      kind_q[wptr_q]  <= kind_in;
      flags_q[wptr_q] <= flags_in;
      pay_q[wptr_q]   <= s_payload_i;
      tag_q[wptr_q]   <= s_tag_i;
    end
  end

endmodule

[src/tfsp_back.sv]
// back end: linked entry store, list walk, unlink and result register
module tfsp_back #(
  parameter int unsigned QUEUE_DEPTH  = tfsp_pkg::QueueDepth,
  parameter int unsigned PAYLOAD_BITS = tfsp_pkg::PayloadBits,
  parameter int unsigned TAG_BITS     = tfsp_pkg::TagBits
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    req_valid_i,
  output logic                    req_ready_o,
  input  tfsp_pkg::req_type_e     req_kind_i,
  input  tfsp_pkg::pop_flags_t    req_flags_i,
  input  logic [PAYLOAD_BITS-1:0] req_payload_i,
  input  logic [TAG_BITS-1:0]     req_tag_i,
  output logic                    res_valid_o,
  input  logic                    res_ready_i,
  output tfsp_pkg::status_e       res_status_o,
  output logic [PAYLOAD_BITS-1:0] res_payload_o,
  output logic [TAG_BITS-1:0]     res_tag_o
);

  localparam int unsigned IW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  // entry store
  logic [PAYLOAD_BITS-1:0] pay_mem  [QUEUE_DEPTH];
  logic [TAG_BITS-1:0]     tag_mem  [QUEUE_DEPTH];
  logic [IW-1:0]           next_mem [QUEUE_DEPTH];
  logic [IW-1:0]           prev_mem [QUEUE_DEPTH];

  logic [PAYLOAD_BITS-1:0] pay_rd_q;
  logic [TAG_BITS-1:0]     tag_rd_q;
  logic [IW-1:0]           next_raw_q, prev_rd_q, raddr_q;
  logic                    fresh_q;
  logic [IW-1:0]           next_rd, rd_addr;

  logic          pay_we, next_we, prev_we;
  logic [IW-1:0] pay_wa, next_wa, next_wd, prev_wa, prev_wd;

  tfsp_pkg::seq_state_e st_q, st_d;
  logic [IW-1:0] head_q, head_d, tail_q, tail_d, free_q, free_d, cur_q, cur_d;
  logic [CW-1:0] used_q, used_d, hwm_q, hwm_d, cnt_q, cnt_d, cnt_n;
  logic          term_q, term_d;

  logic [PAYLOAD_BITS-1:0] arg_pay_q, arg_pay_d;
  logic [TAG_BITS-1:0]     arg_tag_q, arg_tag_d;
  tfsp_pkg::pop_flags_t    arg_flags_q, arg_flags_d;

  tfsp_pkg::status_e       rs_status_q, rs_status_d;
  logic [PAYLOAD_BITS-1:0] rs_pay_q, rs_pay_d;
  logic [TAG_BITS-1:0]     rs_tag_q, rs_tag_d;

  logic                    out_valid_q, out_valid_d;
  tfsp_pkg::status_e       out_status_q;
  logic [PAYLOAD_BITS-1:0] out_pay_q;
  logic [TAG_BITS-1:0]     out_tag_q;
  logic                    out_load, out_free, hit;
  tfsp_pkg::status_e       miss_status;

  function automatic logic [IW-1:0] inc_slot(input logic [IW-1:0] a);
    inc_slot = (a == IW'(QUEUE_DEPTH - 1)) ? '0 : a + 1'b1;
  endfunction

  // slots at or above the high-water mark still hold the reset free chain
  assign next_rd = fresh_q ? inc_slot(raddr_q) : next_raw_q;

  always_ff @(posedge clk_i) begin
    pay_rd_q   <= pay_mem[rd_addr];
    tag_rd_q   <= tag_mem[rd_addr];
    next_raw_q <= next_mem[rd_addr];
    prev_rd_q  <= prev_mem[rd_addr];
    raddr_q    <= rd_addr;
    fresh_q    <= (CW'(rd_addr) >= hwm_q);
    if (pay_we) begin
      pay_mem[pay_wa] <= arg_pay_q;
      tag_mem[pay_wa] <= arg_tag_q;
    end
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
  end

  assign out_free    = !out_valid_q || res_ready_i;
  assign hit         = arg_flags_q.match_any || (tag_rd_q == arg_tag_q);
  assign cnt_n       = cnt_q + 1'b1;
  assign miss_status = (arg_flags_q.blocking && term_q) ? tfsp_pkg::STAT_END
                                                        : tfsp_pkg::STAT_BLOCK;
  assign req_ready_o = (st_q == tfsp_pkg::S_IDLE);

  always_comb begin
    st_d        = st_q;
    head_d      = head_q;
    tail_d      = tail_q;
    free_d      = free_q;
    cur_d       = cur_q;
    used_d      = used_q;
    hwm_d       = hwm_q;
    cnt_d       = cnt_q;
    term_d      = term_q;
    arg_pay_d   = arg_pay_q;
    arg_tag_d   = arg_tag_q;
    arg_flags_d = arg_flags_q;
    rs_status_d = rs_status_q;
    rs_pay_d    = rs_pay_q;
    rs_tag_d    = rs_tag_q;
    rd_addr     = cur_q;
    pay_we      = 1'b0;
    pay_wa      = free_q;
    next_we     = 1'b0;
    next_wa     = cur_q;
    next_wd     = '0;
    prev_we     = 1'b0;
    prev_wa     = free_q;
    prev_wd     = '0;
    out_load    = 1'b0;
    unique case (st_q)
      tfsp_pkg::S_IDLE: begin
        if (req_valid_i) begin
          arg_pay_d   = req_payload_i;
          arg_tag_d   = req_tag_i;
          arg_flags_d = req_flags_i;
          rs_status_d = tfsp_pkg::STAT_OK;
          rs_pay_d    = '0;
          rs_tag_d    = '0;
          st_d        = tfsp_pkg::S_RESP;
          unique case (req_kind_i)
            tfsp_pkg::REQ_PUSH: begin
              if (term_q) begin
                rs_status_d = tfsp_pkg::STAT_END;
              end else if (used_q == CW'(QUEUE_DEPTH)) begin
                rs_status_d = tfsp_pkg::STAT_FULL;
              end else begin
                rd_addr = free_q;
                st_d    = tfsp_pkg::S_PUSH_ALLOC;
              end
            end
            tfsp_pkg::REQ_POP: begin
              if (used_q == '0) begin
                rs_status_d = (req_flags_i.blocking && term_q) ? tfsp_pkg::STAT_END
                                                               : tfsp_pkg::STAT_BLOCK;
              end else begin
                rd_addr = head_q;
                cur_d   = head_q;
                cnt_d   = '0;
                st_d    = tfsp_pkg::S_WALK;
              end
            end
            tfsp_pkg::REQ_TERM: begin
              term_d = 1'b1;
            end
            tfsp_pkg::REQ_NONE: begin
            end
            default: begin
            end
          endcase
        end
      end
      tfsp_pkg::S_PUSH_ALLOC: begin
        // free_q is the slot taken; next_rd is its free-chain successor
        free_d  = next_rd;
        pay_we  = 1'b1;
        next_we = 1'b1;
        next_wa = free_q;
        next_wd = '0;
        prev_we = 1'b1;
        prev_wa = free_q;
        prev_wd = (used_q == '0) ? '0 : tail_q;
        if (used_q == '0) begin
          head_d = free_q;
          st_d   = tfsp_pkg::S_RESP;
        end else begin
          cur_d = tail_q;
          st_d  = tfsp_pkg::S_PUSH_LINK;
        end
        tail_d = free_q;
        used_d = used_q + 1'b1;
        if (CW'(free_q) == hwm_q) begin
          hwm_d = hwm_q + 1'b1;
        end
      end
      tfsp_pkg::S_PUSH_LINK: begin
        // old tail points forward to the new tail
        next_we = 1'b1;
        next_wa = cur_q;
        next_wd = tail_q;
        st_d    = tfsp_pkg::S_RESP;
      end
      tfsp_pkg::S_WALK: begin
        if (hit) begin
          rs_pay_d = pay_rd_q;
          rs_tag_d = tag_rd_q;
          st_d     = tfsp_pkg::S_UNLINK;
        end else if (cnt_n == used_q) begin
          rs_status_d = miss_status;
          st_d        = tfsp_pkg::S_RESP;
        end else begin
          cnt_d   = cnt_n;
          cur_d   = next_rd;
          rd_addr = next_rd;
        end
      end
      tfsp_pkg::S_UNLINK: begin
        priority if (used_q == CW'(1)) begin
          head_d = '0;
          tail_d = '0;
        end else if (cur_q == head_q) begin
          head_d = next_rd;
        end else if (cur_q == tail_q) begin
          tail_d = prev_rd_q;
        end else begin
          prev_we = 1'b1;
          prev_wa = next_rd;
          prev_wd = prev_rd_q;
          next_we = 1'b1;
          next_wa = prev_rd_q;
          next_wd = next_rd;
        end
        st_d = tfsp_pkg::S_FREE;
      end
      tfsp_pkg::S_FREE: begin
        // freed slot goes to the front of the free list
        next_we = 1'b1;
        next_wa = cur_q;
        next_wd = free_q;
        free_d  = cur_q;
        used_d  = used_q - 1'b1;
        st_d    = tfsp_pkg::S_RESP;
      end
      tfsp_pkg::S_RESP: begin
        if (out_free) begin
          out_load = 1'b1;
          st_d     = tfsp_pkg::S_IDLE;
        end
      end
      default: begin
        st_d = tfsp_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= tfsp_pkg::S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      free_q      <= '0;
      cur_q       <= '0;
      used_q      <= '0;
      hwm_q       <= '0;
      cnt_q       <= '0;
      term_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      free_q      <= free_d;
      cur_q       <= cur_d;
      used_q      <= used_d;
      hwm_q       <= hwm_d;
      cnt_q       <= cnt_d;
      term_q      <= term_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    arg_pay_q   <= arg_pay_d;
    arg_tag_q   <= arg_tag_d;
    arg_flags_q <= arg_flags_d;
    rs_status_q <= rs_status_d;
    rs_pay_q    <= rs_pay_d;
    rs_tag_q    <= rs_tag_d;
    if (out_load) begin
      out_status_q <= rs_status_q;
      out_pay_q    <= rs_pay_q;
      out_tag_q    <= rs_tag_q;
    end
  end

  assign res_valid_o   = out_valid_q;
  assign res_status_o  = out_status_q;
  assign res_payload_o = out_pay_q;
  assign res_tag_o     = out_tag_q;

endmodule

[src/tagged_fifo_selective_pop.sv]
// top level of the tagged fifo with selective pop
// Arrival-ordered queue of (payload, tag) entries held in a linked store of
// QUEUE_DEPTH slots with a free list. Every request gives exactly one result.
// A push allocates a slot and, unless the queue was empty, links the old tail
// to it; a refused push, a terminate and an unused request code go straight
// to the result. A pop walks from the head, reading one entry per cycle
// through the single read port of the entry store, then unlinks and frees a
// hit entry; a miss goes to the result once all entries are read. One request
// is worked on at a time; a two-entry request queue in front and the result
// register behind let both sides handshake freely while the back end is busy.
module tagged_fifo_selective_pop #(
  parameter int unsigned QUEUE_DEPTH  = tfsp_pkg::QueueDepth,
  parameter int unsigned PAYLOAD_BITS = tfsp_pkg::PayloadBits,
  parameter int unsigned TAG_BITS     = tfsp_pkg::TagBits
) (
  input  logic clk_i,
  input  logic rst_ni,
  // request channel
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // item_payload, item_tag, match_any, blocking, zero pad to bytes
  input  logic [((PAYLOAD_BITS + TAG_BITS + 2 + 7) / 8) * 8 - 1:0] s_axis_tdata_i,
  // req_type
  input  logic [1:0] s_axis_tuser_i,
  // result channel
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // out_payload, out_tag, zero pad to bytes
  output logic [((PAYLOAD_BITS + TAG_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata_o,
  // status
  output logic [1:0] m_axis_tuser_o
);

  localparam int unsigned MW = ((PAYLOAD_BITS + TAG_BITS + 7) / 8) * 8;

  // front to back request hand-off
  logic                    req_valid, req_ready;
  tfsp_pkg::req_type_e     req_kind;
  tfsp_pkg::pop_flags_t    req_flags;
  logic [PAYLOAD_BITS-1:0] req_payload;
  logic [TAG_BITS-1:0]     req_tag;

  // result register outputs
  tfsp_pkg::status_e       res_status;
  logic [PAYLOAD_BITS-1:0] res_payload;
  logic [TAG_BITS-1:0]     res_tag;

  tfsp_front #(
    .PAYLOAD_BITS(PAYLOAD_BITS),
    .TAG_BITS    (TAG_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid_i),
    .s_ready_o    (s_axis_tready_o),
    .s_type_i     (s_axis_tuser_i),
    .s_payload_i  (s_axis_tdata_i[PAYLOAD_BITS-1:0]),
    .s_tag_i      (s_axis_tdata_i[PAYLOAD_BITS +: TAG_BITS]),
    .s_match_any_i(s_axis_tdata_i[PAYLOAD_BITS + TAG_BITS]),
    .s_blocking_i (s_axis_tdata_i[PAYLOAD_BITS + TAG_BITS + 1]),
    .req_valid_o  (req_valid),
    .req_ready_i  (req_ready),
    .req_kind_o   (req_kind),
    .req_flags_o  (req_flags),
    .req_payload_o(req_payload),
    .req_tag_o    (req_tag)
  );

  tfsp_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PAYLOAD_BITS(PAYLOAD_BITS),
    .TAG_BITS    (TAG_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_valid),
    .req_ready_o  (req_ready),
    .req_kind_i   (req_kind),
    .req_flags_i  (req_flags),
    .req_payload_i(req_payload),
    .req_tag_i    (req_tag),
    .res_valid_o  (m_axis_tvalid_o),
    .res_ready_i  (m_axis_tready_i),
    .res_status_o (res_status),
    .res_payload_o(res_payload),
    .res_tag_o    (res_tag)
  );

  // pack result fields, payload in the low bits
  always_comb begin
    m_axis_tdata_o = '0;
    m_axis_tdata_o[PAYLOAD_BITS-1:0]       = res_payload;
    m_axis_tdata_o[PAYLOAD_BITS +: TAG_BITS] = res_tag;
  end

  assign m_axis_tuser_o = res_status;

  // pad width follows the payload and tag widths
  if (MW < PAYLOAD_BITS + TAG_BITS) begin : g_bad_width
    $error("result bus too narrow");
  end

endmodule

[src/tfsp_checker.sv]
// port-level checker for the tagged fifo, bound to the top level
`include "assert_macros.svh"

module tfsp_checker #(
  parameter int unsigned MW = 48
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          m_axis_tvalid_o,
  input logic          m_axis_tready_i,
  input logic [MW-1:0] m_axis_tdata_o,
  input logic [1:0]    m_axis_tuser_o
);

  // a stalled result keeps its fields
  `TFSP_ASSERT(a_res_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))

  // only a successful pop carries data; any other status has all zero data
  `TFSP_ASSERT(a_fail_zero, clk_i, rst_ni, m_axis_tvalid_o && (m_axis_tuser_o != tfsp_pkg::STAT_OK) |-> (m_axis_tdata_o == '0))

  // no result is offered while reset is held
  `TFSP_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !m_axis_tvalid_o)

endmodule

bind tagged_fifo_selective_pop tfsp_checker #(
  .MW(MW)
) u_tfsp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o),
  .m_axis_tuser_o (m_axis_tuser_o)
);
